### sv/motor_reply_frame_checker_assert.svh
// Assertion helpers used by the checker's parser.
`ifndef MOTOR_REPLY_FRAME_CHECKER_ASSERT_SVH
`define MOTOR_REPLY_FRAME_CHECKER_ASSERT_SVH

// Same-cycle implication, masked while reset is high.
`define MRFC_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is high.
`define MRFC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/mrfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mrfc_pkg;

  localparam logic [7:0] HDR_BYTE = 8'h3E;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_CMD  = 3'd1,
    PH_ID   = 3'd2,
    PH_LEN  = 3'd3,
    PH_HSUM = 3'd4,
    PH_DATA = 3'd5,
    PH_DSUM = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FORMAT   = 2'd1,
    ST_CHECKSUM = 2'd2
  } status_t;

  typedef struct packed {
    logic         valid;
    status_t      status;
    logic [7:0]   command;
    logic [3:0]   length;
    logic [63:0]  payload;
  } result_t;

endpackage

`default_nettype wire

### sv/motor_reply_frame_checker.sv
`timescale 1ns / 1ps
`default_nettype none

// Reply frame checker for a serial motor link.
// s_* carries received bytes, one per request, in s_tdata[7:0]. The checker
// hunts for the 0x3E header, then takes command, id, length and header sum,
// then length data bytes and a data checksum (absent for zero length).
// m_* gives one request per frame: m_tuser holds the status (0 ok, 1 format,
// 2 checksum); m_tdata holds command, length and little-endian payload.
// cfg_* writes the expected device id; cfg_ready is always high.
// Throughput: one byte per cycle while the result register is free, set by
// the single-pass parser between the input register and the result register.
// The byte that ends the frame waits in the input register; the parser's
// combinational outcome for it is then loaded into the result register,
// which drives m_tvalid.
// Reset: bytes and results in flight are dropped, the parser hunts for a
// header, and the device id returns to 1.
// Stall: while m_tready is low the result holds; one more byte waits in the
// input register, after which s_tready drops until the result is taken.
module motor_reply_frame_checker import mrfc_pkg::*; #(
  parameter int MAX_DATA_BYTES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // received byte stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  // frame results
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [79:0]      m_tdata,   // [7:0] command_code, [11:8] data_length,
                                      // [75:12] payload, [79:76] zero
  output logic [1:0]       m_tuser,   // [1:0] frame_status
  // device id register
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic [7:0] device_id;
  logic       out_free;
  logic       step;
  result_t    res;

  assign cfg_ready = 1'b1;
  assign s_tready  = !in_valid || out_free;
  // the byte moves on only once the result register can take its outcome
  assign step      = in_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_id <= 8'd1;
    end else if (cfg_valid) begin
      device_id <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  mrfc_parser #(
    .MAX_DATA_BYTES(MAX_DATA_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .rx_byte   (in_byte),
    .device_id (device_id),
    .res       (res)
  );

  mrfc_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (res.valid),
    .res      (res),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

### sv/mrfc_parser.sv
`timescale 1ns / 1ps
`default_nettype none

`include "motor_reply_frame_checker_assert.svh"

module mrfc_parser import mrfc_pkg::*; #(
  parameter int MAX_DATA_BYTES = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] rx_byte,
  input  wire logic [7:0] device_id,
  output result_t         res
);

  phase_t      phase, phase_next;
  logic [7:0]  frame_command, frame_command_next;
  logic [3:0]  frame_length, frame_length_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [3:0]  byte_count, byte_count_next;
  logic [63:0] payload_store, payload_store_next;

  logic [3:0] count_inc;
  logic [7:0] sum_inc;
  logic       len_bad;

  assign count_inc = byte_count + 4'd1;
  assign sum_inc   = running_sum + rx_byte;
  assign len_bad   = rx_byte > 8'(MAX_DATA_BYTES);

  // next phase
  always_comb begin
    phase_next = phase;
    if (step) begin
      unique case (phase)
        PH_HUNT: phase_next = (rx_byte == HDR_BYTE) ? PH_CMD : PH_HUNT;
        PH_CMD:  phase_next = PH_ID;
        PH_ID:   phase_next = (rx_byte != device_id) ? PH_HUNT : PH_LEN;
        PH_LEN:  phase_next = len_bad ? PH_HUNT : PH_HSUM;
        PH_HSUM: begin
          if (rx_byte != running_sum || frame_length == 4'd0) begin
            phase_next = PH_HUNT;
          end else begin
            phase_next = PH_DATA;
          end
        end
        PH_DATA: phase_next = (count_inc >= frame_length) ? PH_DSUM : PH_DATA;
        PH_DSUM: phase_next = PH_HUNT;
        default: phase_next = PH_HUNT;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    frame_command_next = frame_command;
    frame_length_next  = frame_length;
    running_sum_next   = running_sum;
    byte_count_next    = byte_count;
    payload_store_next = payload_store;
    res                = '0;
    res.command        = frame_command;
    if (step) begin
      unique case (phase)
        PH_CMD: begin
          frame_command_next = rx_byte;
          running_sum_next   = sum_inc;
        end
        PH_ID: begin
          if (rx_byte != device_id) begin
            res.valid  = 1'b1;
            res.status = ST_FORMAT;
          end else begin
            running_sum_next = sum_inc;
          end
        end
        PH_LEN: begin
          if (len_bad) begin
            res.valid  = 1'b1;
            res.status = ST_FORMAT;
          end else begin
            frame_length_next = rx_byte[3:0];
            running_sum_next  = sum_inc;
          end
        end
        PH_HSUM: begin
          if (rx_byte != running_sum) begin
            res.valid  = 1'b1;
            res.status = ST_FORMAT;
            res.length = frame_length;
          end else if (frame_length == 4'd0) begin
            res.valid  = 1'b1;
            res.status = ST_OK;
          end else begin
            running_sum_next   = '0;
            byte_count_next    = '0;
            payload_store_next = '0;
          end
        end
        PH_DATA: begin
          payload_store_next[{byte_count[2:0], 3'b000} +: 8] = rx_byte;
          running_sum_next = sum_inc;
          byte_count_next  = count_inc;
        end
        PH_DSUM: begin
          res.valid  = 1'b1;
          res.length = frame_length;
          if (rx_byte != running_sum) begin
            res.status = ST_CHECKSUM;
          end else begin
            res.status  = ST_OK;
            res.payload = payload_store;
          end
        end
        default: begin
          if (rx_byte == HDR_BYTE) begin
            running_sum_next   = rx_byte;
            frame_command_next = '0;
            frame_length_next  = '0;
            byte_count_next    = '0;
            payload_store_next = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      frame_command <= '0;
      frame_length  <= '0;
      running_sum   <= '0;
      byte_count    <= '0;
      payload_store <= '0;
    end else begin
      phase         <= phase_next;
      frame_command <= frame_command_next;
      frame_length  <= frame_length_next;
      running_sum   <= running_sum_next;
      byte_count    <= byte_count_next;
      payload_store <= payload_store_next;
    end
  end

  `MRFC_ASSERT_NOW(a_res_needs_step, clk, rst, res.valid, step, "result without a byte")
  `MRFC_ASSERT_NOW(a_err_payload_zero, clk, rst, res.valid && res.status != ST_OK,
                   res.payload == '0, "error result carries payload")
  `MRFC_ASSERT_NEXT(a_result_rehunts, clk, rst, res.valid, phase == PH_HUNT,
                    "parser not hunting after a result")
  `MRFC_ASSERT_NOW(a_count_bounded, clk, rst, phase == PH_DATA,
                   byte_count < frame_length, "data count ran past length")

endmodule

`default_nettype wire

### sv/mrfc_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module mrfc_out_stage import mrfc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire result_t     res,
  output logic             free,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [79:0]      m_tdata,
  output logic [1:0]       m_tuser
);

  logic        out_valid;
  status_t     out_status;
  logic [7:0]  out_command;
  logic [3:0]  out_length;
  logic [63:0] out_payload;

  assign free     = !out_valid || m_tready;
  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {4'b0000, out_payload, out_length, out_command};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      out_status  <= res.status;
      out_command <= res.command;
      out_length  <= res.length;
      out_payload <= res.payload;
    end
  end

endmodule

`default_nettype wire

### dv/mrfc_reply_monitor.sv
`timescale 1ns / 1ps

// Watches the byte, result and device id channels of the reply frame checker,
// keeps its own copy of the frame parser and compares every result request.
module mrfc_reply_monitor import mrfc_pkg::*; #(
  parameter int MAX_DATA_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [79:0] m_tdata,
  input  logic [1:0]  m_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  output int          faults,
  output int          backlog
);

  typedef struct packed {
    status_t      status;
    logic [7:0]   command;
    logic [3:0]   length;
    logic [63:0]  payload;
  } frame_reply_t;

  // parser copy
  logic [7:0]   dev_id;
  phase_t       parse_phase;
  logic [7:0]   cmd_q;
  logic [3:0]   len_q;
  logic [7:0]   sum_q;
  logic [3:0]   count_q;
  logic [63:0]  store_q;

  frame_reply_t awaited_replies[$];
  frame_reply_t fresh;
  int           fault_tally = 0;
  int           waiting = 0;
  int           reply_no = 0;

  assign faults  = fault_tally;
  assign backlog = waiting;

  task automatic log_fault(input string msg);
    $display("[%0t] mismatch on result %0d: %s", $realtime, reply_no, msg);
    fault_tally++;
  endtask

  function automatic frame_reply_t close_frame(input status_t st, input logic [3:0] len,
                                               input logic [63:0] pay);
    frame_reply_t r;
    r.status  = st;
    r.command = cmd_q;
    r.length  = len;
    r.payload = pay;
    parse_phase = PH_HUNT;
    return r;
  endfunction

  // One received byte; returns 1 when it closes a frame.
  function automatic bit absorb_byte(input logic [7:0] b, output frame_reply_t r);
    bit done;
    done = 1'b0;
    r = '0;
    case (parse_phase)
      PH_CMD: begin
        cmd_q = b;
        sum_q = sum_q + b;
        parse_phase = PH_ID;
      end
      PH_ID: begin
        // a wrong id ends the frame; the byte is never a new header
        if (b != dev_id) begin
          r = close_frame(ST_FORMAT, 4'd0, 64'd0);
          done = 1'b1;
        end else begin
          sum_q = sum_q + b;
          parse_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        if (b > MAX_DATA_BYTES) begin
          r = close_frame(ST_FORMAT, 4'd0, 64'd0);
          done = 1'b1;
        end else begin
          len_q = b[3:0];
          sum_q = sum_q + b;
          parse_phase = PH_HSUM;
        end
      end
      PH_HSUM: begin
        if (b != sum_q) begin
          r = close_frame(ST_FORMAT, len_q, 64'd0);
          done = 1'b1;
        end else if (len_q == 4'd0) begin
          r = close_frame(ST_OK, 4'd0, 64'd0);
          done = 1'b1;
        end else begin
          sum_q = 8'd0;
          count_q = 4'd0;
          store_q = 64'd0;
          parse_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        store_q = store_q | (64'(b) << (8 * count_q[2:0]));
        sum_q = sum_q + b;
        count_q = count_q + 4'd1;
        if (count_q >= len_q)
          parse_phase = PH_DSUM;
      end
      PH_DSUM: begin
        if (b != sum_q)
          r = close_frame(ST_CHECKSUM, len_q, 64'd0);
        else
          r = close_frame(ST_OK, len_q, store_q);
        done = 1'b1;
      end
      default: begin
        parse_phase = PH_HUNT;
        if (b == HDR_BYTE) begin
          sum_q = b;
          cmd_q = 8'd0;
          len_q = 4'd0;
          count_q = 4'd0;
          store_q = 64'd0;
          parse_phase = PH_CMD;
        end
      end
    endcase
    return done;
  endfunction

  task automatic check_reply();
    frame_reply_t want;
    if (awaited_replies.size() == 0) begin
      log_fault($sformatf("no result expected, got status %0d cmd %02h len %0d",
                          m_tuser, m_tdata[7:0], m_tdata[11:8]));
      return;
    end
    want = awaited_replies.pop_front();
    if (m_tuser !== want.status)
      log_fault($sformatf("status %0d, expected %0d", m_tuser, want.status));
    if (m_tdata[7:0] !== want.command)
      log_fault($sformatf("command %02h, expected %02h", m_tdata[7:0], want.command));
    if (m_tdata[11:8] !== want.length)
      log_fault($sformatf("length %0d, expected %0d", m_tdata[11:8], want.length));
    if (m_tdata[75:12] !== want.payload)
      log_fault($sformatf("payload %016h, expected %016h", m_tdata[75:12], want.payload));
    if (m_tdata[79:76] !== 4'd0)
      log_fault($sformatf("padding %h not zero", m_tdata[79:76]));
    reply_no++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      dev_id = 8'd1;
      parse_phase = PH_HUNT;
      cmd_q = 8'd0;
      len_q = 4'd0;
      sum_q = 8'd0;
      count_q = 4'd0;
      store_q = 64'd0;
      awaited_replies.delete();
    end else begin
      if (m_tvalid && m_tready)
        check_reply();
      if (s_tvalid && s_tready) begin
        if (absorb_byte(s_tdata, fresh))
          awaited_replies.push_back(fresh);
      end
      if (cfg_valid && cfg_ready)
        dev_id = cfg_data;
    end
    waiting <= awaited_replies.size();
  end

endmodule

### dv/motor_reply_frame_checker_test.sv
`timescale 1ns / 1ps

// Top of the reply frame checker bench: clock, reset, byte stimulus, device id
// writes and the verdict. All checking lives in mrfc_reply_monitor.
module motor_reply_frame_checker_test;
  import mrfc_pkg::*;

  localparam int MAX_DATA_BYTES = 8;
  localparam int PHASE_BYTES    = 110;  // frame bytes per device id setting
  localparam int NUM_PHASES     = 5;

  // how a generated frame is spoilt (id and length faults come from the values)
  typedef enum {
    FLAW_NONE,
    FLAW_HEADER_SUM,
    FLAW_DATA_SUM
  } frame_flaw_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = 8'd0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [79:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data  = 8'd0;

  int          faults;
  int          backlog;
  int          frame_bytes = 0;      // bytes sent as part of a frame, noise excluded
  bit          calm = 1'b0;          // no idling on either side while set
  logic [7:0]  device_id_now = 8'd1; // tracks what the block should hold

  motor_reply_frame_checker #(
    .MAX_DATA_BYTES(MAX_DATA_BYTES)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  mrfc_reply_monitor #(
    .MAX_DATA_BYTES(MAX_DATA_BYTES)
  ) monitor (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .faults    (faults),
    .backlog   (backlog)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result side: stalls about 16 percent of the time, none while calm.
  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(0, 99) >= 16);
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #200_000;
    $display("Regression FAIL");
    $finish;
  end

  // One byte request. Random gaps go in front; s_tvalid is left high after the
  // request so back-to-back bytes need no low cycle between them.
  task automatic push_byte(input logic [7:0] b, input bit in_frame);
    while (!calm && $urandom_range(0, 99) < 16) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    if (in_frame)
      frame_bytes++;
  endtask

  // Drop valid and wait until every result has been taken, then let the
  // pipeline drain (two register stages) with some margin.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (backlog != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_device_id(input logic [7:0] id);
    cfg_valid <= 1'b1;
    cfg_data  <= id;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    device_id_now = id;
  endtask

  // Sends a reply frame. A wrong id or an oversize length ends the frame right
  // there, as does a spoilt header sum; a zero length frame has no checksum.
  task automatic send_reply(input logic [7:0] cmd, input logic [7:0] id,
                            input logic [7:0] len, input logic [63:0] data,
                            input frame_flaw_t flaw);
    logic [7:0] hsum;
    logic [7:0] dsum;
    hsum = HDR_BYTE + cmd + id + len;
    dsum = 8'd0;
    push_byte(HDR_BYTE, 1'b1);
    push_byte(cmd, 1'b1);
    push_byte(id, 1'b1);
    if (id != device_id_now)
      return;
    push_byte(len, 1'b1);
    if (len > MAX_DATA_BYTES)
      return;
    if (flaw == FLAW_HEADER_SUM)
      hsum = hsum ^ 8'($urandom_range(1, 255));
    push_byte(hsum, 1'b1);
    if (flaw == FLAW_HEADER_SUM || len == 8'd0)
      return;
    for (int i = 0; i < len; i++) begin
      push_byte(data[8*i +: 8], 1'b1);
      dsum = dsum + data[8*i +: 8];
    end
    if (flaw == FLAW_DATA_SUM)
      dsum = dsum ^ 8'($urandom_range(1, 255));
    push_byte(dsum, 1'b1);
  endtask

  // Mostly clean frames with random content, the rest faulty or line noise.
  task automatic random_reply();
    int          pick;
    int          n;
    logic [7:0]  cmd;
    logic [7:0]  len;
    logic [63:0] data;
    pick = $urandom_range(0, 99);
    cmd  = 8'($urandom);
    len  = 8'($urandom_range(0, MAX_DATA_BYTES));
    data = {$urandom, $urandom};
    if (pick < 64)
      send_reply(cmd, device_id_now, len, data, FLAW_NONE);
    else if (pick < 71)
      send_reply(cmd, device_id_now ^ 8'($urandom_range(1, 255)), len, data, FLAW_NONE);
    else if (pick < 77)
      send_reply(cmd, device_id_now, 8'($urandom_range(MAX_DATA_BYTES + 1, 255)), data,
                 FLAW_NONE);
    else if (pick < 84)
      send_reply(cmd, device_id_now, len, data, FLAW_HEADER_SUM);
    else if (pick < 92)
      send_reply(cmd, device_id_now, 8'($urandom_range(1, MAX_DATA_BYTES)), data,
                 FLAW_DATA_SUM);
    else begin
      // stray bytes between frames; the odd 0x3E among them opens a bogus frame
      n = $urandom_range(1, 4);
      repeat (n) push_byte(8'($urandom), 1'b0);
    end
  endtask

  initial begin
    logic [7:0] phase_ids [NUM_PHASES];
    int         target;
    // first setting is the reset id, then the extremes, the header value
    // itself and a random one
    phase_ids[0] = 8'h01;
    phase_ids[1] = 8'h00;
    phase_ids[2] = 8'hFF;
    phase_ids[3] = HDR_BYTE;
    phase_ids[4] = 8'($urandom);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: noise while hunting, zero length frame, one data byte,
    // an id byte that looks like a header, oversize length, bad header sum
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    send_reply(8'hFF, 8'h01, 8'd0, 64'd0, FLAW_NONE);
    send_reply(8'h00, 8'h01, 8'd1, 64'hFF, FLAW_NONE);
    send_reply(8'h12, HDR_BYTE, 8'd0, 64'd0, FLAW_NONE);
    send_reply(8'h12, 8'h01, 8'd9, 64'd0, FLAW_NONE);
    send_reply(8'h12, 8'h01, 8'd0, 64'd0, FLAW_HEADER_SUM);

    // random phases, one per device id; the middle one runs with no idling
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        settle();
        set_device_id(phase_ids[p]);
      end
      calm = (p == 2);
      target = frame_bytes + PHASE_BYTES;
      while (frame_bytes < target)
        random_reply();
    end
    calm = 1'b0;

    settle();
    repeat (8) @(posedge clk);
    if (faults == 0 && backlog == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
